// ===== hdl/vshg_pkg.sv =====
// ----------------------------------------------------------------------------
// vshg_pkg
// shared types, constants and helpers of the stack and heap guard
// ----------------------------------------------------------------------------
package vshg_pkg;

   localparam int MEM_BYTES          = 65536;
   localparam int STACK_MARGIN_BYTES = 64;
   localparam int MIN_HEAP_BYTES     = 16384;
   localparam int CELL_BYTES         = 4;
   localparam int CELL_COUNT         = MEM_BYTES / CELL_BYTES;
   localparam int ROW_W              = $clog2(CELL_COUNT);
   localparam int STEP_W             = 3;
   localparam int RST_MEM_BYTES      = (MIN_HEAP_BYTES > MEM_BYTES) ? MEM_BYTES
                                                                     : MIN_HEAP_BYTES;

   localparam logic signed [31:0] NO_SCOPE  = -32'sd1;
   localparam logic signed [31:0] MARGIN    = 32'(STACK_MARGIN_BYTES);
   localparam logic signed [31:0] CELL_S    = 32'(CELL_BYTES);
   localparam logic signed [31:0] RST_STACK = 32'(RST_MEM_BYTES - CELL_BYTES);

   typedef enum logic [3:0] {
      OP_INIT     = 4'd0,
      OP_PUSH     = 4'd1,
      OP_POP      = 4'd2,
      OP_ADD      = 4'd3,
      OP_ALLOC    = 4'd4,
      OP_READ     = 4'd5,
      OP_WRITE    = 4'd6,
      OP_FREAD    = 4'd7,
      OP_FWRITE   = 4'd8,
      OP_TPUSH    = 4'd9,
      OP_TPOP     = 4'd10,
      OP_ENTER    = 4'd11,
      OP_LEAVE    = 4'd12,
      OP_FPUSH    = 4'd13,
      OP_FPOP     = 4'd14,
      OP_CHECK    = 4'd15
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_STACK_LOW   = 3'd1,
      ST_STACK_MIN   = 3'd2,
      ST_HEAP_LOW    = 3'd3,
      ST_HEAP_MIN    = 3'd4,
      ST_INVALID     = 3'd5,
      ST_TRACKER     = 3'd6
   } st_type;

   typedef enum logic [1:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_EXEC,
      CS_RESP
   } ctl_state_type;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [31:0] address;
      logic signed [31:0] value;
      logic signed [31:0] amount;
   } req_type_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] read_value;
      logic signed [31:0] heap_ptr;
      logic signed [31:0] stack_ptr;
      logic signed [31:0] frame_ptr;
   } rsp_type;

   typedef struct packed {
      logic              accept;
      logic              exec;
      logic [STEP_W-1:0] step;
      logic              clear;
      logic [ROW_W-1:0]  row;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic init;
   } dp_sts_type;

   // address outside every live region
   function automatic logic bad_addr(input logic signed [31:0] a,
                                     input logic signed [31:0] h,
                                     input logic signed [31:0] s,
                                     input logic signed [31:0] b);
      return (a < 0) || ((a >= h) && (a < s)) || (a >= b);
   endfunction

endpackage

// ===== hdl/vshg_ram.sv =====
// ----------------------------------------------------------------------------
// vshg_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module vshg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

endmodule

// ===== hdl/vshg_datapath.sv =====
// ----------------------------------------------------------------------------
// vshg_datapath
// pointer registers, config registers, byte-lane cell memory and checks
// ----------------------------------------------------------------------------
module vshg_datapath import vshg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  dp_cmd_type   cmd,
   output dp_sts_type   sts,
   input  logic         csr_valid,
   input  logic         csr_index,
   input  logic [16:0]  csr_data,
   input  req_type_type req_data,
   output rsp_type      rsp_data
);

   logic [15:0]        data_size_ff;
   logic [16:0]        heap_req_ff;
   logic signed [31:0] heap_ff, heap_in;
   logic signed [31:0] stack_ff, stack_in;
   logic signed [31:0] base_ff, base_in;
   logic signed [31:0] frame_ff, frame_in;
   logic signed [31:0] scope_ff, scope_in;
   req_type_type       req_ff, req_in;
   st_type             status_ff, status_in;
   logic signed [31:0] rv_ff, rv_in;
   logic signed [31:0] tmp_ff, tmp_in;
   logic [1:0]         rd_rot_ff;
   logic [3:0]         rd_ok_ff;

   // memory access request
   logic               mem_rd, mem_wr;
   logic signed [31:0] mem_a, mem_wd;
   logic [1:0]         lane_off [4];
   logic [31:0]        lane_ba [4];
   logic [3:0]         lane_ok;
   logic [3:0]         lane_we;
   logic [ROW_W-1:0]   lane_row [4];
   logic [7:0]         lane_wd [4];
   logic [7:0]         lane_q [4];
   logic [31:0]        rd_cell;
   logic signed [31:0] rd_s;

   // common sums
   logic signed [31:0] ds_s, amt, addr_eff;
   logic signed [31:0] s_m4, s_p4, h_p4, h_m4, h_m_ds, h_diff;
   logic signed [31:0] ns_add, nh_add, end_p;
   logic [16:0]        m_max;
   logic [17:0]        m_rnd;
   logic [31:0]        m_lo, m_1, m_fin;
   op_type             op;

   assign op     = op_type'(req_ff.req_type);
   assign ds_s   = signed'({16'd0, data_size_ff});
   assign amt    = req_ff.amount;
   assign s_m4   = stack_ff - CELL_S;
   assign s_p4   = stack_ff + CELL_S;
   assign h_p4   = heap_ff + CELL_S;
   assign h_m4   = heap_ff - CELL_S;
   assign h_m_ds = heap_ff - ds_s;
   assign h_diff = stack_ff - heap_ff;
   assign ns_add = stack_ff + amt;
   assign nh_add = heap_ff + amt;
   assign rd_s   = signed'(rd_cell);
   assign end_p  = s_p4 + signed'({rd_cell[29:0], 2'b00});
   assign addr_eff = ((op == OP_FREAD) || (op == OP_FWRITE)) ? frame_ff + req_ff.address
                                                            : req_ff.address;

   // memory size chosen at init
   assign m_max = (heap_req_ff >= {1'b0, data_size_ff}) ? heap_req_ff : {1'b0, data_size_ff};
   assign m_rnd = ({1'b0, m_max} + 18'd3) & ~18'd3;
   assign m_lo  = 32'(data_size_ff) + 32'(MIN_HEAP_BYTES);
   assign m_1   = (32'(m_rnd) < m_lo) ? m_lo : 32'(m_rnd);
   assign m_fin = (m_1 > 32'(MEM_BYTES)) ? 32'(MEM_BYTES) : m_1;

   always_comb begin
      heap_in   = heap_ff;
      stack_in  = stack_ff;
      base_in   = base_ff;
      frame_in  = frame_ff;
      scope_in  = scope_ff;
      req_in    = req_ff;
      status_in = status_ff;
      rv_in     = rv_ff;
      tmp_in    = tmp_ff;
      mem_rd    = 1'b0;
      mem_wr    = 1'b0;
      mem_a     = heap_ff;
      mem_wd    = '0;
      sts       = '0;
      if (cmd.accept) begin
         req_in    = req_data;
         status_in = ST_OK;
         rv_in     = '0;
      end else if (cmd.exec) begin
         sts.last = 1'b1;
         case (op)
            OP_INIT: begin
               sts.init = 1'b1;
               heap_in  = ds_s;
               stack_in = signed'(m_fin - 32'(CELL_BYTES));
               base_in  = signed'(m_fin - 32'(CELL_BYTES));
               frame_in = signed'(m_fin - 32'(CELL_BYTES));
               scope_in = NO_SCOPE;
            end
            OP_PUSH: begin
               if (stack_ff <= h_p4) begin
                  status_in = ST_STACK_LOW;
               end else begin
                  stack_in = s_m4;
                  mem_wr   = 1'b1;
                  mem_a    = s_m4;
                  mem_wd   = req_ff.value;
               end
            end
            OP_POP: begin
               if (cmd.step == '0) begin
                  if (stack_ff >= base_ff) begin
                     status_in = ST_STACK_MIN;
                  end else begin
                     mem_rd   = 1'b1;
                     mem_a    = stack_ff;
                     sts.last = 1'b0;
                  end
               end else begin
                  rv_in    = rd_s;
                  stack_in = s_p4;
               end
            end
            OP_ADD: begin
               if (amt < 0) begin
                  if (ns_add < heap_ff + MARGIN) begin
                     status_in = ST_STACK_LOW;
                  end else begin
                     stack_in = ns_add;
                  end
               end else if (ns_add > base_ff) begin
                  status_in = ST_STACK_MIN;
               end else begin
                  stack_in = ns_add;
               end
            end
            OP_ALLOC: begin
               if ((amt < 0) && (nh_add < ds_s)) begin
                  status_in = ST_HEAP_MIN;
               end else if ((amt >= 0) && (nh_add + MARGIN > stack_ff)) begin
                  status_in = ST_HEAP_LOW;
               end else begin
                  rv_in   = heap_ff;
                  heap_in = nh_add;
               end
            end
            OP_READ, OP_FREAD: begin
               if (cmd.step == '0) begin
                  if (bad_addr(addr_eff, heap_ff, stack_ff, base_ff)) begin
                     status_in = ST_INVALID;
                  end else begin
                     mem_rd   = 1'b1;
                     mem_a    = addr_eff;
                     sts.last = 1'b0;
                  end
               end else begin
                  rv_in = rd_s;
               end
            end
            OP_WRITE, OP_FWRITE: begin
               if (bad_addr(addr_eff, heap_ff, stack_ff, base_ff)) begin
                  status_in = ST_INVALID;
               end else begin
                  mem_wr = 1'b1;
                  mem_a  = addr_eff;
                  mem_wd = req_ff.value;
               end
            end
            OP_TPUSH: begin
               if (amt[31] || (h_diff < MARGIN)) begin
                  status_in = ST_TRACKER;
               end else begin
                  mem_wr  = 1'b1;
                  mem_a   = heap_ff;
                  mem_wd  = amt;
                  heap_in = h_p4;
               end
            end
            OP_TPOP: begin
               if (cmd.step == '0) begin
                  if (h_m_ds < CELL_S) begin
                     status_in = ST_TRACKER;
                  end else begin
                     heap_in  = h_m4;
                     mem_rd   = 1'b1;
                     mem_a    = h_m4;
                     sts.last = 1'b0;
                  end
               end else if ((rd_s < 0) || (h_m_ds < rd_s)) begin
                  status_in = ST_TRACKER;
               end else begin
                  heap_in = heap_ff - rd_s;
               end
            end
            OP_ENTER: begin
               if (h_p4 + MARGIN > stack_ff) begin
                  status_in = ST_HEAP_LOW;
               end else begin
                  scope_in = heap_ff;
                  heap_in  = h_p4;
                  if (bad_addr(heap_ff, h_p4, stack_ff, base_ff)) begin
                     status_in = ST_INVALID;
                  end else begin
                     mem_wr = 1'b1;
                     mem_a  = heap_ff;
                     mem_wd = scope_ff;
                  end
               end
            end
            OP_LEAVE: begin
               if (cmd.step == '0) begin
                  if (bad_addr(scope_ff, heap_ff, stack_ff, base_ff)) begin
                     status_in = ST_INVALID;
                  end else begin
                     mem_rd   = 1'b1;
                     mem_a    = scope_ff;
                     sts.last = 1'b0;
                  end
               end else begin
                  heap_in  = scope_ff;
                  scope_in = rd_s;
                  if ((rd_s != NO_SCOPE) && bad_addr(rd_s, scope_ff, stack_ff, base_ff)) begin
                     status_in = ST_INVALID;
                  end
               end
            end
            OP_FPUSH: begin
               case (cmd.step)
                  3'd0: begin
                     if (stack_ff <= h_p4) begin
                        status_in = ST_STACK_LOW;
                     end else begin
                        stack_in = s_m4;
                        mem_wr   = 1'b1;
                        mem_a    = s_m4;
                        mem_wd   = frame_ff;
                        sts.last = 1'b0;
                     end
                  end
                  3'd1: begin
                     if (h_p4 + MARGIN > stack_ff) begin
                        status_in = ST_HEAP_LOW;
                     end else begin
                        tmp_in  = heap_ff;
                        heap_in = h_p4;
                        if (bad_addr(heap_ff, h_p4, stack_ff, base_ff)) begin
                           status_in = ST_INVALID;
                        end else begin
                           mem_wr   = 1'b1;
                           mem_a    = heap_ff;
                           mem_wd   = scope_ff;
                           sts.last = 1'b0;
                        end
                     end
                  end
                  default: begin
                     if (stack_ff <= h_p4) begin
                        status_in = ST_STACK_LOW;
                     end else begin
                        stack_in = s_m4;
                        frame_in = s_m4;
                        mem_wr   = 1'b1;
                        mem_a    = s_m4;
                        mem_wd   = tmp_ff;
                     end
                  end
               endcase
            end
            OP_FPOP: begin
               case (cmd.step)
                  3'd0: begin
                     // stack unwinds to the frame first, kept even on failure
                     stack_in = frame_ff;
                     if (frame_ff >= base_ff) begin
                        status_in = ST_STACK_MIN;
                     end else begin
                        mem_rd   = 1'b1;
                        mem_a    = frame_ff;
                        sts.last = 1'b0;
                     end
                  end
                  3'd1: begin
                     // saved heap pointer popped
                     stack_in = s_p4;
                     if (bad_addr(rd_s, heap_ff, s_p4, base_ff)) begin
                        status_in = ST_INVALID;
                     end else begin
                        tmp_in   = rd_s;
                        mem_rd   = 1'b1;
                        mem_a    = rd_s;
                        sts.last = 1'b0;
                     end
                  end
                  3'd2: begin
                     scope_in = rd_s;
                     heap_in  = tmp_ff;
                     if (($unsigned(tmp_ff) < 32'(data_size_ff)) || (tmp_ff > stack_ff)) begin
                        status_in = ST_INVALID;
                     end else if (stack_ff >= base_ff) begin
                        status_in = ST_STACK_MIN;
                     end else begin
                        mem_rd   = 1'b1;
                        mem_a    = stack_ff;
                        sts.last = 1'b0;
                     end
                  end
                  3'd3: begin
                     frame_in = rd_s;
                     stack_in = s_p4;
                     if (s_p4 >= base_ff) begin
                        status_in = ST_STACK_MIN;
                     end else begin
                        mem_rd   = 1'b1;
                        mem_a    = s_p4;
                        sts.last = 1'b0;
                     end
                  end
                  default: begin
                     // argument count popped, then dropped from the stack
                     if ((rd_s < 0) || (end_p > base_ff)) begin
                        stack_in  = s_p4;
                        status_in = ST_STACK_MIN;
                     end else begin
                        stack_in = end_p;
                     end
                  end
               endcase
            end
            OP_CHECK: begin
               if (bad_addr(req_ff.address, heap_ff, stack_ff, base_ff)) begin
                  status_in = ST_INVALID;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   // byte lanes: byte i of a cell at address a lives in lane (a + i) mod 4
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         lane_off[l] = 2'(l) - mem_a[1:0];
         lane_ba[l]  = $unsigned(mem_a) + 32'(lane_off[l]);
         lane_ok[l]  = lane_ba[l] < 32'(MEM_BYTES);
         lane_wd[l]  = 8'(mem_wd >> {lane_off[l], 3'b000});
         lane_row[l] = lane_ba[l][ROW_W+1:2];
         lane_we[l]  = mem_wr & lane_ok[l];
         if (cmd.clear) begin
            lane_row[l] = cmd.row;
            lane_wd[l]  = '0;
            lane_we[l]  = 1'b1;
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      vshg_ram #(
         .WIDTH (8),
         .DEPTH (CELL_COUNT)
      ) u_ram (
         .clock    (clock),
         .we       (lane_we[g]),
         .addr     (lane_row[g]),
         .wdata    (lane_wd[g]),
         .rdata_ff (lane_q[g])
      );
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rd_cell[8*i +: 8] = rd_ok_ff[i] ? lane_q[2'(rd_rot_ff + 2'(i))] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_size_ff <= '0;
         heap_req_ff  <= '0;
         heap_ff      <= '0;
         stack_ff     <= RST_STACK;
         base_ff      <= RST_STACK;
         frame_ff     <= RST_STACK;
         scope_ff     <= NO_SCOPE;
      end else begin
         if (csr_valid) begin
            if (csr_index == 1'b0) begin
               data_size_ff <= csr_data[15:0];
            end else begin
               heap_req_ff <= csr_data;
            end
         end
         heap_ff  <= heap_in;
         stack_ff <= stack_in;
         base_ff  <= base_in;
         frame_ff <= frame_in;
         scope_ff <= scope_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      rv_ff     <= rv_in;
      tmp_ff    <= tmp_in;
      if (mem_rd) begin
         rd_rot_ff <= mem_a[1:0];
         rd_ok_ff  <= {lane_ok[mem_a[1:0] + 2'd3], lane_ok[mem_a[1:0] + 2'd2],
                       lane_ok[mem_a[1:0] + 2'd1], lane_ok[mem_a[1:0]]};
      end
   end

   // read valid flags are kept per byte of the cell, lanes rotate on read
   always_comb begin
      rsp_data.status     = status_ff;
      rsp_data.read_value = rv_ff;
      rsp_data.heap_ptr   = heap_ff;
      rsp_data.stack_ptr  = stack_ff;
      rsp_data.frame_ptr  = frame_ff;
   end

endmodule

// ===== hdl/vshg_ctrl.sv =====
// ----------------------------------------------------------------------------
// vshg_ctrl
// request sequencer: accept, step through an operation, clear sweep, respond
// ----------------------------------------------------------------------------
module vshg_ctrl import vshg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   ctl_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              init_ff, init_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_CLEAR;
         step_ff  <= '0;
         row_ff   <= '0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         row_ff   <= row_in;
         init_ff  <= init_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      row_in    = row_ff;
      init_in   = init_ff;
      cmd       = '0;
      cmd.step  = step_ff;
      cmd.row   = row_ff;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         CS_CLEAR: begin
            cmd.clear = 1'b1;
            row_in    = row_ff + 1'b1;
            if (row_ff == ROW_W'(CELL_COUNT - 1)) begin
               row_in   = '0;
               init_in  = 1'b0;
               state_in = init_ff ? CS_RESP : CS_IDLE;
            end
         end
         CS_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               step_in    = '0;
               state_in   = CS_EXEC;
            end
         end
         CS_EXEC: begin
            cmd.exec = 1'b1;
            step_in  = step_ff + 1'b1;
            if (sts.last) begin
               if (sts.init) begin
                  init_in  = 1'b1;
                  row_in   = '0;
                  state_in = CS_CLEAR;
               end else begin
                  state_in = CS_RESP;
               end
            end
         end
         CS_RESP: begin
            rsp_valid = 1'b1;
            state_in  = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/vm_stack_heap_guard.sv =====
// ----------------------------------------------------------------------------
// vm_stack_heap_guard
// cell memory of a script machine with guarded heap, stack and frames
// ----------------------------------------------------------------------------
// usage
//  - request channel: drive req_data and raise start; the beat is taken at
//    an edge where start is high and busy is low
//  - result channel: one beat per request, rsp_data valid for exactly one
//    cycle while rsp_valid is high; the receiver cannot stall, so results
//    are never held back
//  - csr channel: csr_index 0 writes data_size, 1 writes heap_request;
//    csr_ready is always high, write only while busy is low
//  - sequencing: a request runs 1 to 5 steps in the sequencer, one cell
//    access a step, and the next start is taken the cycle after the
//    result strobe (1 step for most requests, 2 for pops, reads, tracker
//    pop and scope leave, 3 for frame push, 5 for frame pop, set by the
//    chain of dependent reads through the registered memory)
//  - init clears the cell memory one row a cycle, all 16384 rows
//    (CELL_COUNT), before its result
//  - reset: pointers take their init values for zero registers, then the
//    same clearing sweep runs with busy high and no result
// ----------------------------------------------------------------------------
module vm_stack_heap_guard import vshg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [16:0]  csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // config writes are always taken
   assign csr_ready = 1'b1;

   // sequencer
   vshg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // pointers, checks and cell memory
   vshg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_data  (rsp_data)
   );

   // one result beat per request, then back to idle
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("not idle after result");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stack and heap guard: a queue-fed driver issues
// requests and register writes, a monitor checks every result beat against a
// cycle-free predictor of the cell memory, its pointers and its scopes
// ----------------------------------------------------------------------------
module tb;
   import vshg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic { ITEM_REQ, ITEM_CFG } item_kind_type;
   // address anchors, resolved against the predicted pointers or data size when driven
   typedef enum logic [2:0] { AM_RAW, AM_STACK, AM_DATA, AM_BASE, AM_HEAP } anchor_type;
   localparam logic CSR_DATA_SIZE = 1'b0;
   localparam logic CSR_HEAP_REQ  = 1'b1;
   localparam int   QUIET_LIMIT   = 60000;
   localparam int   ITEM_TARGET   = 1850;

   typedef struct {
      item_kind_type      kind;
      op_type             op;
      anchor_type         anchor;
      logic signed [31:0] address;
      logic signed [31:0] value;
      logic signed [31:0] amount;
      logic               csr_idx;
      logic [16:0]        csr_val;
   } item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_type_type req_data = '0;
   logic         rsp_valid;
   rsp_type      rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [16:0]  csr_data = '0;

   vm_stack_heap_guard dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   // mirror of the block state
   logic [31:0]        p_data_size, p_heap_req, p_mem_size;
   logic signed [31:0] p_heap, p_stack, p_base, p_frame, p_scope;
   logic [31:0]        p_cells [CELL_COUNT];

   item_type pend_q [$];
   rsp_type  exp_rsp_q [$];
   int       err_count = 0;
   int       gap_left = 0;
   int       quiet = 0;

   function automatic logic [7:0] byte_rd(input logic [31:0] a);
      if (a >= MEM_BYTES) return 8'h00;
      return p_cells[a >> 2] >> (a[1:0] * 8);
   endfunction

   function automatic void byte_wr(input logic [31:0] a, input logic [7:0] b);
      logic [31:0] w;
      if (a >= MEM_BYTES) return;
      w = p_cells[a >> 2];
      w[a[1:0]*8 +: 8] = b;
      p_cells[a >> 2] = w;
   endfunction

   // little-endian cell at any byte address, bytes beyond the store read zero
   function automatic logic signed [31:0] cell_rd(input logic signed [31:0] a);
      logic [31:0] v;
      v = '0;
      for (int i = 3; i >= 0; i--) v = {v[23:0], byte_rd(a + i)};
      return v;
   endfunction

   function automatic void cell_wr(input logic signed [31:0] a, input logic [31:0] v);
      for (int i = 0; i < 4; i++) byte_wr(a + i, v[8*i +: 8]);
   endfunction

   function automatic void mem_init();
      logic [31:0] m;
      m = p_heap_req;
      if (m < p_data_size) m = p_data_size;
      m = (m + 3) & ~32'd3;
      if (m < p_data_size + MIN_HEAP_BYTES) m = p_data_size + MIN_HEAP_BYTES;
      if (m > MEM_BYTES) m = MEM_BYTES;
      p_mem_size = m;
      foreach (p_cells[i]) p_cells[i] = '0;
      p_heap  = p_data_size;
      p_stack = m - 4;
      p_base  = m - 4;
      p_frame = m - 4;
      p_scope = NO_SCOPE;
   endfunction

   function automatic logic outside(input logic signed [31:0] a);
      return a < 0 || (a >= p_heap && a < p_stack) || a >= p_base;
   endfunction

   function automatic st_type cell_push(input logic signed [31:0] v);
      if (p_stack <= p_heap + 32'sd4) return ST_STACK_LOW;
      p_stack = p_stack - 32'sd4;
      cell_wr(p_stack, v);
      return ST_OK;
   endfunction

   function automatic st_type cell_pop(output logic signed [31:0] v);
      v = '0;
      if (p_stack >= p_base) return ST_STACK_MIN;
      v = cell_rd(p_stack);
      p_stack = p_stack + 32'sd4;
      return ST_OK;
   endfunction

   function automatic st_type heap_grow(input logic signed [31:0] amt,
                                        output logic signed [31:0] old);
      logic signed [31:0] nh;
      old = '0;
      nh = p_heap + amt;
      if (amt < 0) begin
         if (nh < $signed(p_data_size)) return ST_HEAP_MIN;
      end else if (nh + MARGIN > p_stack) begin
         return ST_HEAP_LOW;
      end
      old = p_heap;
      p_heap = nh;
      return ST_OK;
   endfunction

   function automatic st_type stack_adjust(input logic signed [31:0] amt);
      logic signed [31:0] ns;
      ns = p_stack + amt;
      if (amt < 0) begin
         if (ns < p_heap + MARGIN) return ST_STACK_LOW;
      end else if (ns > p_base) begin
         return ST_STACK_MIN;
      end
      p_stack = ns;
      return ST_OK;
   endfunction

   // unwinds one call frame; earlier steps stay applied when a later one fails
   function automatic st_type frame_unwind();
      logic signed [31:0] saved, fb, nargs, stop;
      st_type st;
      p_stack = p_frame;
      st = cell_pop(saved);
      if (st != ST_OK) return st;
      if (outside(saved)) return ST_INVALID;
      p_scope = cell_rd(saved);
      p_heap  = saved;
      if ($unsigned(p_heap) < p_data_size || p_heap > p_stack) return ST_INVALID;
      st = cell_pop(fb);
      if (st != ST_OK) return st;
      p_frame = fb;
      st = cell_pop(nargs);
      if (st != ST_OK) return st;
      stop = p_stack + (nargs * 4);
      if (nargs < 0 || stop > p_base) return ST_STACK_MIN;
      p_stack = stop;
      return ST_OK;
   endfunction

   function automatic rsp_type run_request(input req_type_type rq);
      rsp_type            r;
      st_type             st;
      logic signed [31:0] a, rv, tmp, prev;
      st = ST_OK;
      rv = '0;
      tmp = '0;
      a = rq.address;
      case (op_type'(rq.req_type))
         OP_INIT:  mem_init();
         OP_PUSH:  st = cell_push(rq.value);
         OP_POP: begin
            st = cell_pop(tmp);
            if (st == ST_OK) rv = tmp;
         end
         OP_ADD:   st = stack_adjust(rq.amount);
         OP_ALLOC: begin
            st = heap_grow(rq.amount, tmp);
            if (st == ST_OK) rv = tmp;
         end
         OP_READ, OP_FREAD: begin
            if (rq.req_type == OP_FREAD) a = p_frame + a;
            if (outside(a)) st = ST_INVALID;
            else rv = cell_rd(a);
         end
         OP_WRITE, OP_FWRITE: begin
            if (rq.req_type == OP_FWRITE) a = p_frame + a;
            if (outside(a)) st = ST_INVALID;
            else cell_wr(a, rq.value);
         end
         OP_TPUSH: begin
            if (rq.amount < 0 || (p_stack - p_heap) < MARGIN) st = ST_TRACKER;
            else begin
               cell_wr(p_heap, rq.amount);
               p_heap = p_heap + 32'sd4;
            end
         end
         OP_TPOP: begin
            if ((p_heap - $signed(p_data_size)) < 4) st = ST_TRACKER;
            else begin
               p_heap = p_heap - 32'sd4;
               tmp = cell_rd(p_heap);
               if (tmp < 0 || (p_heap - $signed(p_data_size)) < tmp) st = ST_TRACKER;
               else p_heap = p_heap - tmp;
            end
         end
         OP_ENTER: begin
            prev = p_scope;
            st = heap_grow(32'sd4, tmp);
            if (st == ST_OK) begin
               p_scope = tmp;
               if (outside(p_scope)) st = ST_INVALID;
               else cell_wr(p_scope, prev);
            end
         end
         OP_LEAVE: begin
            if (outside(p_scope)) st = ST_INVALID;
            else begin
               tmp = cell_rd(p_scope);
               p_heap = p_scope;
               p_scope = tmp;
               if (p_scope != NO_SCOPE && outside(p_scope)) st = ST_INVALID;
            end
         end
         OP_FPUSH: begin
            st = cell_push(p_frame);
            if (st == ST_OK) st = heap_grow(32'sd4, tmp);
            if (st == ST_OK && outside(tmp)) st = ST_INVALID;
            if (st == ST_OK) begin
               cell_wr(tmp, p_scope);
               st = cell_push(tmp);
               if (st == ST_OK) p_frame = p_stack;
            end
         end
         OP_FPOP:  st = frame_unwind();
         default:  if (outside(a)) st = ST_INVALID;
      endcase
      r.status     = st;
      r.read_value = rv;
      r.heap_ptr   = p_heap;
      r.stack_ptr  = p_stack;
      r.frame_ptr  = p_frame;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic void add_req(input op_type op, input anchor_type an,
                                   input logic [31:0] addr, input logic [31:0] val,
                                   input logic [31:0] amt);
      item_type it;
      it = '{kind: ITEM_REQ, op: op, anchor: an, address: addr, value: val,
             amount: amt, csr_idx: 1'b0, csr_val: '0};
      pend_q.push_back(it);
   endfunction

   function automatic void add_cfg(input logic idx, input logic [16:0] val);
      item_type it;
      it = '{kind: ITEM_CFG, op: OP_INIT, anchor: AM_RAW, address: '0, value: '0,
             amount: '0, csr_idx: idx, csr_val: val};
      pend_q.push_back(it);
   endfunction

   function automatic logic [31:0] near_off();
      return $signed($urandom_range(0, 48)) - 24;
   endfunction

   function automatic logic [31:0] small_amt();
      return $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) - 20
                                       : ($signed($urandom_range(0, 16)) - 8) * 4;
   endfunction

   function automatic anchor_type any_anchor();
      return anchor_type'($urandom_range(0, 4));
   endfunction

   // one random sequence; mostly well-formed, some broken or pure noise
   function automatic void add_sequence();
      int n;
      n = $urandom_range(1, 6);
      case ($urandom_range(0, 10))
         0: begin
            repeat (n) add_req(OP_PUSH, AM_RAW, '0, $urandom, '0);
            repeat (n + $urandom_range(0, 1)) add_req(OP_POP, AM_RAW, '0, '0, '0);
         end
         1: begin
            add_req(OP_TPUSH, AM_RAW, '0, '0, $urandom_range(0, 3) * 4);
            add_req(OP_TPUSH, AM_RAW, '0, '0, $urandom_range(0, 24));
            repeat ($urandom_range(1, 3)) add_req(OP_TPOP, AM_RAW, '0, '0, '0);
         end
         2: begin
            add_req(OP_ENTER, AM_RAW, '0, '0, '0);
            repeat ($urandom_range(0, 3)) add_req(OP_ALLOC, AM_RAW, '0, '0, small_amt());
            add_req(OP_WRITE, AM_HEAP, -near_off() & 32'hFFFF_FFFC, $urandom, '0);
            add_req(OP_LEAVE, AM_RAW, '0, '0, '0);
         end
         3, 4: begin
            n = $urandom_range(0, 3);
            repeat (n) add_req(OP_PUSH, AM_RAW, '0, $urandom, '0);
            add_req(OP_PUSH, AM_RAW, '0, $urandom_range(0, 3) == 0 ? n + 1 : n, '0);
            add_req(OP_FPUSH, AM_RAW, '0, '0, '0);
            if ($urandom_range(0, 1)) add_req(OP_ENTER, AM_RAW, '0, '0, '0);
            repeat ($urandom_range(1, 3)) begin
               add_req(OP_FWRITE, AM_RAW, near_off(), $urandom, '0);
               add_req(OP_FREAD, AM_RAW, near_off(), '0, '0);
            end
            if ($urandom_range(0, 1)) add_req(OP_PUSH, AM_RAW, '0, $urandom, '0);
            add_req(OP_FPOP, AM_RAW, '0, '0, '0);
         end
         5: repeat (n) begin
            add_req($urandom_range(0, 1) ? OP_READ : OP_WRITE, any_anchor(),
                    near_off(), $urandom, '0);
         end
         6: repeat (n) begin
            add_req($urandom_range(0, 1) ? OP_ALLOC : OP_ADD, AM_RAW, '0, '0,
                    $urandom_range(0, 7) == 0 ? $urandom : small_amt());
         end
         7: repeat (n) add_req(OP_CHECK, any_anchor(), near_off(), '0, '0);
         8: begin
            add_req(op_type'($urandom_range(1, 15)), AM_RAW, $urandom, $urandom, $urandom);
         end
         9: begin
            add_req(op_type'($urandom_range(1, 15)), any_anchor(), near_off(),
                    $urandom, small_amt());
         end
         default: begin
            add_req($urandom_range(0, 1) ? OP_FPOP : OP_LEAVE, AM_RAW, '0, '0, '0);
            add_req(OP_TPOP, AM_RAW, '0, '0, '0);
         end
      endcase
   endfunction

   // directed opening against the reset layout
   function automatic void add_directed();
      add_req(OP_CHECK, AM_RAW, 32'hFFFF_FFFF, '0, '0);
      add_req(OP_CHECK, AM_RAW, 32'h0000_0000, '0, '0);
      add_req(OP_CHECK, AM_RAW, 32'h7FFF_FFFF, '0, '0);
      add_req(OP_CHECK, AM_RAW, 32'h8000_0000, '0, '0);
      add_req(OP_POP, AM_RAW, '0, '0, '0);
      add_req(OP_PUSH, AM_RAW, '0, 32'h7FFF_FFFF, '0);
      add_req(OP_PUSH, AM_RAW, '0, 32'h8000_0000, '0);
      add_req(OP_WRITE, AM_STACK, 32'd1, 32'hFFFF_FFFF, '0);
      add_req(OP_READ, AM_STACK, 32'd2, '0, '0);
      add_req(OP_READ, AM_BASE, 32'd0, '0, '0);
      add_req(OP_POP, AM_RAW, '0, '0, '0);
      add_req(OP_ADD, AM_RAW, '0, '0, -32'sd8);
      add_req(OP_ADD, AM_RAW, '0, '0, 32'sd8);
      add_req(OP_ALLOC, AM_RAW, '0, '0, -32'sd4);
      add_req(OP_TPUSH, AM_RAW, '0, '0, 32'hFFFF_FFFF);
      add_req(OP_TPOP, AM_RAW, '0, '0, '0);
      add_req(OP_TPUSH, AM_RAW, '0, '0, 32'd8);
      add_req(OP_TPOP, AM_RAW, '0, '0, '0);
      add_req(OP_LEAVE, AM_RAW, '0, '0, '0);
      add_req(OP_ENTER, AM_RAW, '0, '0, '0);
      add_req(OP_FPUSH, AM_RAW, '0, '0, '0);
      add_req(OP_FWRITE, AM_RAW, 32'd4, 32'h1234_5678, '0);
      add_req(OP_FREAD, AM_RAW, 32'd0, '0, '0);
      add_req(OP_FPOP, AM_RAW, '0, '0, '0);
      add_req(OP_LEAVE, AM_RAW, '0, '0, '0);
      // wrapping sums on the extreme deltas, then a fresh layout
      add_req(OP_ALLOC, AM_RAW, '0, '0, 32'h7FFF_FFFF);
      add_req(OP_ADD, AM_RAW, '0, '0, 32'h8000_0000);
      add_req(OP_INIT, AM_RAW, '0, '0, '0);
   endfunction

   initial begin
      int phase;
      logic [16:0] ds_set [8];
      logic [16:0] hr_set [8];
      ds_set = '{17'd0, 17'd49152, 17'd100, 17'd1000,
                 17'd49152, 17'd0, 17'd3, 17'd40000};
      hr_set = '{17'd65536, 17'd65536, 17'd5, 17'd0,
                 17'd0, 17'd65535, 17'd70, 17'd131071};
      p_data_size = '0;
      p_heap_req  = '0;
      mem_init();
      add_directed();
      for (phase = 0; phase < 8; phase++) begin
         add_cfg(CSR_DATA_SIZE, ds_set[phase]);
         add_cfg(CSR_HEAP_REQ, hr_set[phase]);
         add_req(OP_INIT, AM_RAW, '0, '0, '0);
         // live data size: move it after the init in one phase
         if (phase == 3) add_cfg(CSR_DATA_SIZE, 17'd600);
         while (pend_q.size() < (phase + 1) * ITEM_TARGET / 8) add_sequence();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // drain: all beats issued and every result back
      do @(posedge clock);
      while (pend_q.size() != 0 || exp_rsp_q.size() != 0 || start || csr_valid);
      repeat (20) @(posedge clock);
      if (err_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- driver
   function automatic req_type_type place_item(input item_type it);
      req_type_type rq;
      logic signed [31:0] anchor_val;
      case (it.anchor)
         AM_STACK: anchor_val = p_stack;
         AM_DATA:  anchor_val = p_data_size;
         AM_BASE:  anchor_val = p_base;
         AM_HEAP:  anchor_val = p_heap;
         default:  anchor_val = '0;
      endcase
      rq.req_type = it.op;
      rq.address  = anchor_val + it.address;
      rq.value    = it.value;
      rq.amount   = it.amount;
      return rq;
   endfunction

   always @(posedge clock) begin : drive
      logic took_req, took_cfg, n_start, n_csr;
      took_req = start && !busy;
      took_cfg = csr_valid && csr_ready;
      n_start = 1'b0;
      n_csr = 1'b0;
      if (!reset) begin
         if (took_req) begin
            exp_rsp_q.push_back(run_request(req_data));
            void'(pend_q.pop_front());
            // random idle bursts, none in the closing stretch
            if (pend_q.size() > 150 && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 8);
         end
         if (took_cfg) begin
            if (csr_index == CSR_DATA_SIZE) p_data_size = csr_data[15:0];
            else p_heap_req = csr_data;
            void'(pend_q.pop_front());
         end
         if (start && !took_req) n_start = 1'b1;
         else if (csr_valid && !took_cfg) n_csr = 1'b1;
         else if (gap_left > 0) gap_left--;
         else if (pend_q.size() != 0) begin
            if (pend_q[0].kind == ITEM_REQ) begin
               n_start = 1'b1;
               req_data <= place_item(pend_q[0]);
            end else if (!took_cfg && !took_req && !busy && exp_rsp_q.size() == 0) begin
               // register write only with the block idle
               n_csr = 1'b1;
               csr_index <= pend_q[0].csr_idx;
               csr_data <= pend_q[0].csr_val;
            end
         end
      end
      start <= n_start;
      csr_valid <= n_csr;
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (exp_rsp_q.size() == 0) begin
            $error("unexpected result beat %p", rsp_data);
            err_count++;
         end else begin
            want = exp_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               err_count++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value expected %h actual %h", want.read_value,
                      rsp_data.read_value);
               err_count++;
            end
            if (rsp_data.heap_ptr !== want.heap_ptr) begin
               $error("heap_ptr expected %h actual %h", want.heap_ptr, rsp_data.heap_ptr);
               err_count++;
            end
            if (rsp_data.stack_ptr !== want.stack_ptr) begin
               $error("stack_ptr expected %h actual %h", want.stack_ptr,
                      rsp_data.stack_ptr);
               err_count++;
            end
            if (rsp_data.frame_ptr !== want.frame_ptr) begin
               $error("frame_ptr expected %h actual %h", want.frame_ptr,
                      rsp_data.frame_ptr);
               err_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat at all; covers the clearing sweeps
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
hdl/vshg_pkg.sv
hdl/vshg_ram.sv
hdl/vshg_datapath.sv
hdl/vshg_ctrl.sv
hdl/vm_stack_heap_guard.sv
verif/tb.sv
